### rtl/core/cached_dithered_palette_quantizer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the palette quantizer
// Concurrent checks that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef CACHED_DITHERED_PALETTE_QUANTIZER_DEFINES_SVH
`define CACHED_DITHERED_PALETTE_QUANTIZER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define CDPQ_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cdpq assertion failed");
// Next-cycle implication
`define CDPQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cdpq assertion failed");
`else
`define CDPQ_ASSERT_IMP(name, clk, rst, ante, cons)
`define CDPQ_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

### rtl/core/cdpq_pkg.sv
// ----------------------------------------------------------------------------
// cdpq_pkg
// Types and constants shared by the palette quantizer modules.
// ----------------------------------------------------------------------------
package cdpq_pkg;

   localparam int CHAN_W  = 6;
   localparam int INDEX_W = 8;
   localparam int DIST_W  = 14;
   localparam int ERR_W   = 7;
   localparam int LINE_W  = 12;

   localparam logic [1:0] KIND_PALETTE = 2'd0;
   localparam logic [1:0] KIND_CLEAR   = 2'd1;
   localparam logic [1:0] KIND_PIXEL   = 2'd2;

   localparam logic       CSR_DITHER_ENABLE = 1'b0;
   localparam logic       CSR_PALETTE_SIZE  = 1'b1;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 6'd63;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic               valid;
      rgb_type            tag;
      logic [INDEX_W-1:0] index;
   } cache_line_type;

   typedef struct packed {
      logic               wr_en;
      logic [INDEX_W-1:0] wr_addr;
      rgb_type            wr_rgb;
      logic               rd_en;
      logic [INDEX_W-1:0] rd_addr;
      logic               start;
      logic [INDEX_W-1:0] last;
      rgb_type            pix;
   } srch_ctrl_type;

   typedef struct packed {
      logic               done;
      logic [INDEX_W-1:0] best;
      rgb_type            rd_rgb;
   } srch_sts_type;

endpackage

### rtl/core/cached_dithered_palette_quantizer.sv
// ----------------------------------------------------------------------------
// cached_dithered_palette_quantizer
// Maps 6-bit RGB pixels to the nearest palette index through a direct-mapped
// result cache, with optional error-diffusion dither.
//
//   channel | dir | handshake              | payload
//   req     | in  | req_tvalid/req_tready  | tuser kind, tdata index+RGB
//   rsp     | out | rsp_tvalid/rsp_tready  | tdata color_index
//   csr     | in  | csr_valid/csr_ready    | csr_index, csr_data
//
// One transaction at a time. Palette write and unknown kind stay in S_IDLE.
// Pixel hit: S_CREAD, S_CHECK, S_OUT, with S_EREAD before S_OUT under dither.
// Pixel miss adds S_SEARCH, over the single palette read port, and S_FILL.
// Clear, and reset, sweep the 4096-line cache with req_tready low.
// A result held on rsp stalls only the next pixel at its final cycle.
// ----------------------------------------------------------------------------
`include "cached_dithered_palette_quantizer_defines.svh"

module cached_dithered_palette_quantizer #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // entry_index[7:0], red[13:8], green[19:14], blue[25:20]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // color_index[7:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [8:0]  csr_data
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CLEAR  = 3'd1;
   localparam logic [2:0] S_CREAD  = 3'd2;
   localparam logic [2:0] S_CHECK  = 3'd3;
   localparam logic [2:0] S_SEARCH = 3'd4;
   localparam logic [2:0] S_FILL   = 3'd5;
   localparam logic [2:0] S_EREAD  = 3'd6;
   localparam logic [2:0] S_OUT    = 3'd7;

   localparam int CACHE_DEPTH = 4096;

   typedef logic signed [cdpq_pkg::ERR_W-1:0] err_type;

   logic [2:0]  state_ff, state_in;
   logic        dither_ff;
   logic [8:0]  pal_size_ff;
   cdpq_pkg::rgb_type pix_ff, pix_in;
   logic [cdpq_pkg::INDEX_W-1:0] chosen_ff, chosen_in;
   logic [cdpq_pkg::LINE_W-1:0]  clr_cnt_ff, clr_cnt_in;
   err_type     err_r_ff, err_r_in, err_g_ff, err_g_in, err_b_ff, err_b_in;
   logic        rsp_vld_ff, rsp_vld_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;

   cdpq_pkg::cache_line_type cache_mem [CACHE_DEPTH];
   cdpq_pkg::cache_line_type cache_rd_ff;

   cdpq_pkg::srch_ctrl_type srch_ctrl;
   cdpq_pkg::srch_sts_type  srch_sts;

   logic        req_acc;
   logic        hit;
   logic [cdpq_pkg::LINE_W-1:0] line;
   cdpq_pkg::rgb_type req_rgb, dith_rgb;
   logic [8:0]  last9;

   function automatic logic [5:0] dither_chan(input logic [5:0] c, input err_type e);
      logic signed [7:0] s;
      s = $signed({2'b00, c}) + 8'(e);
      if (s < 0) begin
         return '0;
      end else if (s > $signed(8'(cdpq_pkg::CHAN_MAX))) begin
         return cdpq_pkg::CHAN_MAX;
      end
      return s[5:0];
   endfunction

   // 3*(p - q)/4, truncated towards zero
   function automatic err_type new_err(input logic [5:0] p, input logic [5:0] q);
      logic signed [6:0] d;
      logic signed [8:0] t;
      logic [8:0]        m;
      logic [6:0]        h;
      d = $signed({1'b0, p}) - $signed({1'b0, q});
      t = 9'(d) + (9'(d) <<< 1);
      m = t[8] ? 9'(-t) : 9'(t);
      h = m[8:2];
      return t[8] ? err_type'(-h) : err_type'(h);
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign req_rgb.red   = req_tdata[13:8];
   assign req_rgb.green = req_tdata[19:14];
   assign req_rgb.blue  = req_tdata[25:20];

   assign dith_rgb.red   = dither_chan(req_rgb.red,   err_r_ff);
   assign dith_rgb.green = dither_chan(req_rgb.green, err_g_ff);
   assign dith_rgb.blue  = dither_chan(req_rgb.blue,  err_b_ff);

   assign line = {pix_ff.red[3:0], pix_ff.green[3:0], pix_ff.blue[3:0]};
   assign hit  = cache_rd_ff.valid && (cache_rd_ff.tag == pix_ff);

   // search bound: zero counts as one, oversize saturates
   always_comb begin
      priority if (pal_size_ff == '0) begin
         last9 = '0;
      end else if (pal_size_ff > 9'(PALETTE_DEPTH)) begin
         last9 = 9'(PALETTE_DEPTH - 1);
      end else begin
         last9 = pal_size_ff - 1'b1;
      end
   end

   always_comb begin
      srch_ctrl.wr_en   = req_acc && (req_tuser == cdpq_pkg::KIND_PALETTE);
      srch_ctrl.wr_addr = req_tdata[7:0];
      srch_ctrl.wr_rgb  = req_rgb;
      srch_ctrl.rd_en   = (state_ff == S_EREAD);
      srch_ctrl.rd_addr = chosen_ff;
      srch_ctrl.start   = (state_ff == S_CHECK) && !hit;
      srch_ctrl.last    = last9[7:0];
      srch_ctrl.pix     = pix_ff;
   end

   cdpq_search #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) u_search (
      .clock(clock),
      .reset(reset),
      .ctrl (srch_ctrl),
      .sts  (srch_sts)
   );

   always_comb begin
      state_in    = state_ff;
      pix_in      = pix_ff;
      chosen_in   = chosen_ff;
      clr_cnt_in  = clr_cnt_ff;
      err_r_in    = err_r_ff;
      err_g_in    = err_g_ff;
      err_b_in    = err_b_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               unique case (req_tuser)
                  cdpq_pkg::KIND_CLEAR: begin
                     err_r_in   = '0;
                     err_g_in   = '0;
                     err_b_in   = '0;
                     clr_cnt_in = '0;
                     state_in   = S_CLEAR;
                  end
                  cdpq_pkg::KIND_PIXEL: begin
                     pix_in   = dither_ff ? dith_rgb : req_rgb;
                     state_in = S_CREAD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (&clr_cnt_ff) begin
               state_in = S_IDLE;
            end
         end
         S_CREAD: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (hit) begin
               chosen_in = cache_rd_ff.index;
               state_in  = dither_ff ? S_EREAD : S_OUT;
            end else begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (srch_sts.done) begin
               chosen_in = srch_sts.best;
               state_in  = S_FILL;
            end
         end
         S_FILL: begin
            state_in = dither_ff ? S_EREAD : S_OUT;
         end
         S_EREAD: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = chosen_ff;
               if (dither_ff) begin
                  err_r_in = new_err(pix_ff.red,   srch_sts.rd_rgb.red);
                  err_g_in = new_err(pix_ff.green, srch_sts.rd_rgb.green);
                  err_b_in = new_err(pix_ff.blue,  srch_sts.rd_rgb.blue);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // one access per cycle, and every write lands before the next read
   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) begin
         cache_mem[clr_cnt_ff] <= '0;
      end else if (state_ff == S_FILL) begin
         cache_mem[line] <= '{valid: 1'b1, tag: pix_ff, index: chosen_ff};
      end
      if (state_ff == S_CREAD) begin
         cache_rd_ff <= cache_mem[line];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_cnt_ff  <= '0;
         err_r_ff    <= '0;
         err_g_ff    <= '0;
         err_b_ff    <= '0;
         rsp_vld_ff  <= 1'b0;
         dither_ff   <= 1'b0;
         pal_size_ff <= 9'd256;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         err_r_ff   <= err_r_in;
         err_g_ff   <= err_g_in;
         err_b_ff   <= err_b_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               cdpq_pkg::CSR_DITHER_ENABLE: dither_ff   <= csr_data[0];
               cdpq_pkg::CSR_PALETTE_SIZE:  pal_size_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
      pix_ff      <= pix_in;
      chosen_ff   <= chosen_in;
      rsp_data_ff <= rsp_data_in;
   end

   `CDPQ_ASSERT_IMP(a_err_r_range, clock, reset, 1'b1, (err_r_ff >= -7'sd47) && (err_r_ff <= 7'sd47))
   `CDPQ_ASSERT_IMP(a_rsp_from_out, clock, reset, $rose(rsp_vld_ff), $past(state_ff) == S_OUT)
   `CDPQ_ASSERT_NEXT(a_fill_then_emit, clock, reset, state_ff == S_FILL, (state_ff == S_EREAD) || (state_ff == S_OUT))
   `CDPQ_ASSERT_IMP(a_done_in_search, clock, reset, srch_sts.done, state_ff == S_SEARCH)

endmodule

### rtl/core/cdpq_search.sv
// ----------------------------------------------------------------------------
// cdpq_search
// Palette memory with a sequential nearest-colour search, one entry per cycle.
// ----------------------------------------------------------------------------
`include "cached_dithered_palette_quantizer_defines.svh"

module cdpq_search #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cdpq_pkg::srch_ctrl_type ctrl,
   output cdpq_pkg::srch_sts_type  sts
);

   localparam int PW = $clog2(PALETTE_DEPTH);

   cdpq_pkg::rgb_type pal_mem [PALETTE_DEPTH];
   cdpq_pkg::rgb_type rd_data_ff;

   logic          issuing_ff,  issuing_in;
   logic [PW-1:0] issue_ff,    issue_in;
   logic          ret_vld_ff,  ret_vld_in;
   logic [PW-1:0] ret_addr_ff, ret_addr_in;
   logic          done_ff,     done_in;
   logic [PW-1:0] best_ff,     best_in;
   logic [cdpq_pkg::DIST_W-1:0] best_dist_ff, best_dist_in;

   logic          rd_en;
   logic [PW-1:0] rd_addr;
   logic [PW-1:0] last;
   logic          wr_ok;
   logic [cdpq_pkg::DIST_W-1:0] cand_dist;

   function automatic logic [11:0] sq_diff(input logic [5:0] a, input logic [5:0] b);
      logic [5:0] m;
      m = (a >= b) ? (a - b) : (b - a);
      return 12'(m) * 12'(m);
   endfunction

   assign last    = ctrl.last[PW-1:0];
   assign wr_ok   = ctrl.wr_en && ({1'b0, ctrl.wr_addr} < 9'(PALETTE_DEPTH));
   assign rd_en   = issuing_ff || ctrl.rd_en;
   assign rd_addr = issuing_ff ? issue_ff : ctrl.rd_addr[PW-1:0];

   assign cand_dist = cdpq_pkg::DIST_W'(sq_diff(ctrl.pix.red,   rd_data_ff.red))
                    + cdpq_pkg::DIST_W'(sq_diff(ctrl.pix.green, rd_data_ff.green))
                    + cdpq_pkg::DIST_W'(sq_diff(ctrl.pix.blue,  rd_data_ff.blue));

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         pal_mem[ctrl.wr_addr[PW-1:0]] <= ctrl.wr_rgb;
      end
      if (rd_en) begin
         rd_data_ff <= pal_mem[rd_addr];
      end
   end

   always_comb begin
      issuing_in   = issuing_ff;
      issue_in     = issue_ff;
      ret_vld_in   = issuing_ff;
      ret_addr_in  = issue_ff;
      best_in      = best_ff;
      best_dist_in = best_dist_ff;
      done_in      = ret_vld_ff && (ret_addr_ff == last);
      if (ctrl.start) begin
         issuing_in = 1'b1;
         issue_in   = '0;
      end else if (issuing_ff) begin
         if (issue_ff == last) begin
            issuing_in = 1'b0;
         end else begin
            issue_in = issue_ff + 1'b1;
         end
      end
      // first entry seeds, later ones win only when strictly closer
      if (ret_vld_ff && ((ret_addr_ff == '0) || (cand_dist < best_dist_ff))) begin
         best_in      = ret_addr_ff;
         best_dist_in = cand_dist;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff <= 1'b0;
         ret_vld_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         issuing_ff <= issuing_in;
         ret_vld_ff <= ret_vld_in;
         done_ff    <= done_in;
      end
      issue_ff     <= issue_in;
      ret_addr_ff  <= ret_addr_in;
      best_ff      <= best_in;
      best_dist_ff <= best_dist_in;
   end

   assign sts.done   = done_ff;
   assign sts.best   = cdpq_pkg::INDEX_W'(best_ff);
   assign sts.rd_rgb = rd_data_ff;

   `CDPQ_ASSERT_IMP(a_ret_in_range, clock, reset, ret_vld_ff, ret_addr_ff <= last)
   `CDPQ_ASSERT_NEXT(a_done_single, clock, reset, done_ff, !done_ff)
   `CDPQ_ASSERT_IMP(a_no_start_busy, clock, reset, ctrl.start, !issuing_ff && !ret_vld_ff)

endmodule
